// File: src/tvdt_pkg.sv
package tvdt_pkg;

    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_W     = 10;
    localparam int COUNT_OUT_W = 11;
    localparam int TOL_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                scan_issue;
        logic                read_issue;
        logic                write;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                use_idx;
        logic                use_rd;
    } tvdt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              compress;
        logic              full;
        logic              eidx_ok;
        logic              scan_done;
        logic              pipe_busy;
        logic              hit;
        logic              out_free;
    } tvdt_stat_t;

endpackage

// File: src/tvdt_ctrl.sv
module tvdt_ctrl
    import tvdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  tvdt_stat_t stat,
    output tvdt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_APPEND   = 3'd3;
    localparam logic [2:0] S_FINISH   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                use_idx_reg, use_idx_next;
    logic                use_rd_reg, use_rd_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        use_idx_next   = use_idx_reg;
        use_rd_next    = use_rd_reg;
        cmd            = '0;
        cmd.out_status = status_reg;
        cmd.use_idx    = use_idx_reg;
        cmd.use_rd     = use_rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                status_next  = STAT_OK;
                use_idx_next = 1'b0;
                use_rd_next  = 1'b0;
                case (stat.func)
                    FUNC_ADD:  state_next = stat.compress ? S_SCAN : S_APPEND;
                    FUNC_FIND: state_next = S_SCAN;
                    FUNC_READ:
                    begin
                        state_next = S_FINISH;
                        if (stat.eidx_ok)
                        begin
                            cmd.read_issue = 1'b1;
                            use_idx_next   = 1'b1;
                            use_rd_next    = 1'b1;
                        end
                        else
                        begin
                            status_next = STAT_RANGE;
                        end
                    end
                    default:   state_next = S_FINISH;
                endcase
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    status_next  = (stat.func == FUNC_ADD) ? STAT_PRESENT : STAT_OK;
                    use_idx_next = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (!stat.scan_done)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else if (!stat.pipe_busy)
                begin
                    // all stored entries scanned without a match
                    if (stat.func == FUNC_ADD)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_APPEND:
            begin
                if (stat.full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    cmd.write    = 1'b1;
                    use_idx_next = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            status_reg  <= STAT_OK;
            use_idx_reg <= 1'b0;
            use_rd_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            use_idx_reg <= use_idx_next;
            use_rd_reg  <= use_rd_next;
        end
    end

endmodule

// File: src/tvdt_datapath.sv
module tvdt_datapath
    import tvdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_BITS  = 32,
    parameter int IN_TDATA_W  = 112,
    parameter int OUT_TDATA_W = 120
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]    m_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  tvdt_cmd_t              cmd,
    output tvdt_stat_t             stat
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
    localparam int VW    = 3 * COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    localparam int TW    = (DW > TOL_W) ? DW : TOL_W;

    logic [VW-1:0] mem [TABLE_DEPTH];

    logic                  compress_reg;
    logic [TOL_W-1:0]      tol_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [VW-1:0]         vert_reg;
    logic [ENTRY_W-1:0]    eidx_reg;
    logic [CNT_W-1:0]      scan_idx_reg;
    logic                  cmp_valid_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [VW-1:0]         rd_data_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [ENTRY_W-1:0]    out_found_reg;
    logic [VW-1:0]         out_vert_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [CMP_W-1:0] eidx_ext;
    logic [CMP_W-1:0] count_ext;
    logic [DW-1:0]    sa, sb, d1, mag;
    logic             match;

    assign eidx_ext  = CMP_W'(eidx_reg);
    assign count_ext = CMP_W'(count_reg);
    assign rd_addr   = cmd.scan_issue ? scan_idx_reg[IDX_W-1:0] : eidx_ext[IDX_W-1:0];

    // per-coordinate exact distance, one bit wider than the coordinate
    always_comb
    begin
        match = 1'b1;
        sa    = '0;
        sb    = '0;
        d1    = '0;
        mag   = '0;
        for (int k = 0; k < 3; k++)
        begin
            sa  = {rd_data_reg[k*COORD_BITS + COORD_BITS - 1],
                   rd_data_reg[k*COORD_BITS +: COORD_BITS]};
            sb  = {vert_reg[k*COORD_BITS + COORD_BITS - 1],
                   vert_reg[k*COORD_BITS +: COORD_BITS]};
            d1  = sa - sb;
            mag = d1[DW-1] ? (sb - sa) : d1;
            if (TW'(mag) >= TW'(tol_reg))
            begin
                match = 1'b0;
            end
        end
    end

    assign stat.func      = func_reg;
    assign stat.compress  = compress_reg;
    assign stat.full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.eidx_ok   = (eidx_ext < count_ext);
    assign stat.scan_done = (scan_idx_reg >= count_reg);
    assign stat.pipe_busy = cmp_valid_reg;
    assign stat.hit       = cmp_valid_reg && match;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_TDATA_W'({out_count_reg, out_vert_reg, out_found_reg});

    // vertex table
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[count_reg[IDX_W-1:0]] <= vert_reg;
        end
        if (cmd.scan_issue || cmd.read_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tuser;
            vert_reg <= s_tdata[VW-1:0];
            eidx_reg <= s_tdata[VW +: ENTRY_W];
        end
        if (cmd.scan_issue)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmp_valid_reg && match)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        else if (cmd.write)
        begin
            hit_idx_reg <= count_reg[IDX_W-1:0];
        end
        else if (cmd.read_issue)
        begin
            hit_idx_reg <= eidx_ext[IDX_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_found_reg  <= cmd.use_idx ? ENTRY_W'(hit_idx_reg) : '0;
            out_vert_reg   <= cmd.use_rd ? rd_data_reg : '0;
            out_count_reg  <= COUNT_OUT_W'(count_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compress_reg  <= 1'b1;
            tol_reg       <= TOL_RESET;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_COMPRESS))
            begin
                compress_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == CFG_TOLERANCE))
            begin
                tol_reg <= cfg_data[TOL_W-1:0];
            end
            if (cmd.write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: src/tolerant_vertex_dedup_table_unit.sv
// tolerant vertex dedup table
// input stream s_*: one word per operation, s_tuser holds the operation code
// (add, find index, read by index), s_tdata the vertex and the entry index.
// output stream m_*: exactly one result word per input word, in order,
// m_tuser holds the status, m_tdata the index, the vertex and the count.
// config port: cfg_we with cfg_index 0 sets compress mode, 1 the match
// tolerance; write only while no operation is in flight.
// one operation is processed at a time. add (compress mode) and find scan the
// stored entries through the single table read port, one entry per cycle,
// with one registered compare stage, up to TABLE_DEPTH entries. add without
// compress, read and unused codes do not scan the table.
// s_tready is high only while the unit waits for a new word.
// the result sits in an output register; a new word is taken while it waits,
// and a stalled receiver only holds the next result in its final step.
// reset empties the table (count zero), sets compress mode on and tolerance
// 66; table contents are not cleared, entries are read only after written.
module tolerant_vertex_dedup_table_unit
    import tvdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_BITS  = 32
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // coord_x, coord_y, coord_z, entry_index, zero fill
    input  logic [((3*COORD_BITS+ENTRY_W+7)/8)*8-1:0]   s_tdata,
    // func
    input  logic [FUNC_W-1:0]                           s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // found_index, out_x, out_y, out_z, stored_count, zero fill
    output logic [((3*COORD_BITS+ENTRY_W+COUNT_OUT_W+7)/8)*8-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]                         m_tuser,
    input  logic                                        cfg_we,
    input  logic [CFG_IDX_W-1:0]                        cfg_index,
    input  logic [CFG_DATA_W-1:0]                       cfg_data
);

    localparam int IN_TDATA_W  = ((3*COORD_BITS + ENTRY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3*COORD_BITS + ENTRY_W + COUNT_OUT_W + 7) / 8) * 8;

    tvdt_cmd_t  cmd;
    tvdt_stat_t stat;

    tvdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tvdt_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS),
        .IN_TDATA_W  (IN_TDATA_W),
        .OUT_TDATA_W (OUT_TDATA_W)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
